### rtl/core/ptoe_pkg.sv
// Shared types and constants for the peer table with oldest eviction.
package ptoe_pkg;

    // Field widths
    localparam int NODE_W    = 32;
    localparam int TIME_W    = 32;
    localparam int MASK_W    = 16;
    localparam int EPOCH_W   = 8;
    localparam int SLOT_OUT_W = 4;

    // Default table depth
    localparam int TABLE_SLOTS_DEF = 16;

    // Event kinds
    localparam logic MODE_SEEN   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Controller states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_TAIL   = 7'b0001000,
        ST_PICK   = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input word, reset scan state
        logic res_reject;  // set the pending result to the rejected form
        logic scan_en;     // issue a slot read and advance the scan
        logic pick;        // latch the chosen slot, read its capabilities
        logic update;      // write the slot and form the result
        logic out_load;    // move the pending result into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic reject;      // captured node is zero or our own
        logic scan_last;   // the read being issued is for the last slot
    } t_stat;

    // One capability entry
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [MASK_W-1:0]  exercised;
        logic [MASK_W-1:0]  verified;
        logic [MASK_W-1:0]  declared;
    } t_caps;

endpackage

### rtl/core/ptoe_ctrl.sv
// Controller state machine for the peer table: sequences capture, scan, update and output.
module ptoe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output ptoe_pkg::t_cmd  o_cmd,
    input  ptoe_pkg::t_stat i_stat
);

    ptoe_pkg::t_state r_state;
    ptoe_pkg::t_state n_state;
    logic             r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ptoe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ptoe_pkg::ST_CHECK;
                end
            end
            ptoe_pkg::ST_CHECK: begin
                if (i_stat.reject) begin
                    o_cmd.res_reject = 1'b1;
                    n_state          = ptoe_pkg::ST_FINISH;
                end else begin
                    n_state = ptoe_pkg::ST_SCAN;
                end
            end
            ptoe_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ptoe_pkg::ST_TAIL;
                end
            end
            ptoe_pkg::ST_TAIL: begin
                // last slot is compared in this cycle
                n_state = ptoe_pkg::ST_PICK;
            end
            ptoe_pkg::ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = ptoe_pkg::ST_UPDATE;
            end
            ptoe_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ptoe_pkg::ST_FINISH;
            end
            ptoe_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ptoe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptoe_pkg::ST_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptoe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ptoe_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/ptoe_dpath.sv
// Datapath for the peer table: slot memories, scan compare, slot choice and result register.
module ptoe_dpath #(
    parameter int TABLE_SLOTS = ptoe_pkg::TABLE_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ptoe_pkg::NODE_W-1:0]      i_cfg_wdata,
    input  logic                             i_mode,
    input  logic [ptoe_pkg::NODE_W-1:0]      i_node,
    input  logic [ptoe_pkg::TIME_W-1:0]      i_now_ms,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_declared_mask,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_verified_mask,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_exercised_mask,
    input  logic [ptoe_pkg::EPOCH_W-1:0]     i_report_epoch,
    input  ptoe_pkg::t_cmd                   i_cmd,
    output ptoe_pkg::t_stat                  o_stat,
    output logic                             o_accepted,
    output logic [ptoe_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic                             o_new_peer,
    output logic                             o_caps_changed
);

    localparam int              IdxW    = $clog2(TABLE_SLOTS);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);

    // Own identifier
    logic [ptoe_pkg::NODE_W-1:0]  r_own_id;

    // Captured input word
    logic                         r_mode;
    logic [ptoe_pkg::NODE_W-1:0]  r_node;
    logic [ptoe_pkg::TIME_W-1:0]  r_now;
    logic [ptoe_pkg::MASK_W-1:0]  r_dec;
    logic [ptoe_pkg::MASK_W-1:0]  r_ver;
    logic [ptoe_pkg::MASK_W-1:0]  r_exe;
    logic [ptoe_pkg::EPOCH_W-1:0] r_epoch;

    // Scan state
    logic [IdxW-1:0]              r_rd_idx;
    logic [IdxW-1:0]              r_cmp_idx;
    logic                         r_cmp_vld;
    logic                         r_match_found;
    logic [IdxW-1:0]              r_match_idx;
    logic                         r_free_found;
    logic [IdxW-1:0]              r_free_idx;
    logic                         r_best_vld;
    logic [ptoe_pkg::TIME_W-1:0]  r_best_age;
    logic [IdxW-1:0]              r_old_idx;

    // Per-slot flags
    logic [TABLE_SLOTS-1:0]       r_used;
    logic [TABLE_SLOTS-1:0]       r_reported;

    // Slot memories and their read registers
    logic [ptoe_pkg::NODE_W-1:0]  r_node_mem  [TABLE_SLOTS];
    logic [ptoe_pkg::TIME_W-1:0]  r_heard_mem [TABLE_SLOTS];
    ptoe_pkg::t_caps              r_caps_mem  [TABLE_SLOTS];
    logic [ptoe_pkg::NODE_W-1:0]  r_node_q;
    logic [ptoe_pkg::TIME_W-1:0]  r_heard_q;
    ptoe_pkg::t_caps              r_caps_q;

    // Chosen slot and pending result
    logic [IdxW-1:0]              r_slot;
    logic [IdxW-1:0]              n_slot;
    logic                         r_res_acc;
    logic [IdxW-1:0]              r_res_slot;
    logic                         r_res_new;
    logic                         r_res_chg;

    // Output register
    logic                         r_o_acc;
    logic [ptoe_pkg::SLOT_OUT_W-1:0] r_o_slot;
    logic                         r_o_new;
    logic                         r_o_chg;

    logic                         w_cmp_used;
    logic [ptoe_pkg::TIME_W-1:0]  w_age;
    logic                         w_rep_old;
    logic                         w_diff;
    ptoe_pkg::t_caps              w_caps_wr;

    // Compare stage helpers
    assign w_cmp_used = r_used[r_cmp_idx];
    assign w_age      = r_now - r_heard_q;

    // Slot choice: match, else lowest free, else oldest
    always_comb begin
        if (r_match_found) begin
            n_slot = r_match_idx;
        end else if (r_free_found) begin
            n_slot = r_free_idx;
        end else begin
            n_slot = r_old_idx;
        end
    end

    // Update helpers
    assign w_rep_old = r_match_found && r_reported[r_slot];
    assign w_diff    = (r_dec != r_caps_q.declared) || (r_ver != r_caps_q.verified)
                    || (r_exe != r_caps_q.exercised);

    always_comb begin
        w_caps_wr.epoch     = r_epoch;
        w_caps_wr.declared  = r_dec;
        w_caps_wr.verified  = r_ver & r_dec;
        w_caps_wr.exercised = r_exe & r_ver & r_dec;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_wdata;
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_node  <= i_node;
            r_now   <= i_now_ms;
            r_dec   <= i_declared_mask;
            r_ver   <= i_verified_mask;
            r_exe   <= i_exercised_mask;
            r_epoch <= i_report_epoch;
        end
    end

    // Scan control and running match / free / oldest search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx      <= '0;
            r_cmp_idx     <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_vld    <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx      <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_vld    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_en;
            if (i_cmd.scan_en) begin
                r_cmp_idx <= r_rd_idx;
                r_rd_idx  <= r_rd_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                if (w_cmp_used && (r_node_q == r_node) && !r_match_found) begin
                    r_match_found <= 1'b1;
                    r_match_idx   <= r_cmp_idx;
                end
                if (!w_cmp_used && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                // strictly greater keeps the lowest index on ties
                if (w_cmp_used && (!r_best_vld || (w_age > r_best_age))) begin
                    r_best_vld <= 1'b1;
                    r_best_age <= w_age;
                    r_old_idx  <= r_cmp_idx;
                end
            end
        end
    end

    // Node and last-heard memories: scan read, update write
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_node_mem[r_slot]  <= r_node;
            r_heard_mem[r_slot] <= r_now;
        end
        if (i_cmd.scan_en) begin
            r_node_q  <= r_node_mem[r_rd_idx];
            r_heard_q <= r_heard_mem[r_rd_idx];
        end
    end

    // Capability memory: read at the chosen slot, written on a report
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_mode == ptoe_pkg::MODE_REPORT)) begin
            r_caps_mem[r_slot] <= w_caps_wr;
        end
        if (i_cmd.pick) begin
            r_caps_q <= r_caps_mem[n_slot];
        end
    end

    // Chosen slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_slot <= n_slot;
        end
    end

    // Slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_reported <= '0;
        end else if (i_cmd.update) begin
            r_used[r_slot] <= 1'b1;
            if (r_mode == ptoe_pkg::MODE_REPORT) begin
                r_reported[r_slot] <= 1'b1;
            end else if (!r_match_found) begin
                r_reported[r_slot] <= 1'b0;
            end
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_reject) begin
            r_res_acc  <= 1'b0;
            r_res_slot <= '0;
            r_res_new  <= 1'b0;
            r_res_chg  <= 1'b0;
        end else if (i_cmd.update) begin
            r_res_acc  <= 1'b1;
            r_res_slot <= r_slot;
            if (r_mode == ptoe_pkg::MODE_REPORT) begin
                r_res_new <= !w_rep_old;
                r_res_chg <= w_rep_old && w_diff;
            end else begin
                r_res_new <= !r_match_found;
                r_res_chg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_acc  <= r_res_acc;
            r_o_slot <= ptoe_pkg::SLOT_OUT_W'(r_res_slot);
            r_o_new  <= r_res_new;
            r_o_chg  <= r_res_chg;
        end
    end

    // Status
    assign o_stat.reject    = (r_node == '0) || (r_node == r_own_id);
    assign o_stat.scan_last = (r_rd_idx == LastIdx);

    assign o_accepted     = r_o_acc;
    assign o_slot_index   = r_o_slot;
    assign o_new_peer     = r_o_new;
    assign o_caps_changed = r_o_chg;

endmodule

### rtl/core/peer_table_with_oldest_eviction_top.sv
// Top level of the neighbour table with oldest-first eviction.
//
// Input channel (i_in_valid / o_in_ready) carries one event word: mode, node,
// time and, for reports, the three capability masks and epoch. Output channel
// (o_out_valid / i_out_ready) returns one result word per event: accepted,
// slot index, new peer and capability change flags. The own node identifier
// is to be written via i_cfg_we / i_cfg_wdata only while idle; not enforced.
//
// Timing: one event at a time. An accepted event is checked, then the slots
// are scanned one per cycle through the node and last-heard memory read port,
// then the chosen slot is picked and updated and the result moves to the output
// register; a rejected node goes straight to that result stage. A new event is
// taken only once the previous one has left the result stage.
// The output register holds a result while the receiver stalls; the block
// still takes and works on the next event, and waits before its result stage
// only while the previous result is still unread.
// Reset clears all slots to unused, clears the own node identifier and empties
// the output register. No clearing pass is needed.
module peer_table_with_oldest_eviction_top #(
    parameter int TABLE_SLOTS = ptoe_pkg::TABLE_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ptoe_pkg::NODE_W-1:0]      i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_mode,
    input  logic [ptoe_pkg::NODE_W-1:0]      i_node,
    input  logic [ptoe_pkg::TIME_W-1:0]      i_now_ms,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_declared_mask,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_verified_mask,
    input  logic [ptoe_pkg::MASK_W-1:0]      i_exercised_mask,
    input  logic [ptoe_pkg::EPOCH_W-1:0]     i_report_epoch,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_accepted,
    output logic [ptoe_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic                             o_new_peer,
    output logic                             o_caps_changed
);

    ptoe_pkg::t_cmd  w_cmd;
    ptoe_pkg::t_stat w_stat;

    // Sequencer
    ptoe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Table storage and compare
    ptoe_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_mode),
        .i_node           (i_node),
        .i_now_ms         (i_now_ms),
        .i_declared_mask  (i_declared_mask),
        .i_verified_mask  (i_verified_mask),
        .i_exercised_mask (i_exercised_mask),
        .i_report_epoch   (i_report_epoch),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_accepted       (o_accepted),
        .o_slot_index     (o_slot_index),
        .o_new_peer       (o_new_peer),
        .o_caps_changed   (o_caps_changed)
    );

    // One event in flight: after acceptance the input side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an event is in progress");

    // A rejected word carries no slot or flags
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_slot_index == '0) && !o_new_peer
                                         && !o_caps_changed)
        else $error("rejected result with non-zero fields");

    // A capability change needs an earlier report from an accepted peer
    a_change_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_caps_changed) |-> (o_accepted && !o_new_peer))
        else $error("capability change flagged on a new or rejected peer");

endmodule
